### rtl/tfla_pkg.sv
// Shared constants, types and the pixel expansion function for the tile allocator.
`timescale 1ns / 1ps
`default_nettype none

package tfla_pkg;

    localparam int NUM_TILES = 512;
    localparam int LINK_W    = 10;
    localparam int ADDR_W    = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
    localparam int ROWS      = 8;
    localparam int ROW_W     = 3;
    localparam int PIX_W     = 8;
    localparam int SRC_W     = 16;
    localparam int ID_W      = 16;
    localparam int PAL_W     = 32;
    localparam int HALF_W    = 64;
    localparam int ROWWORD_W = ROWS * PIX_W;
    localparam int S_DATA_W  = 176;
    localparam int M_DATA_W  = 88;

    typedef enum logic [1:0] {
        STS_ALLOCATED = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_FREED     = 2'd2,
        STS_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_LINK,
        ST_ROWS,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    init_wr;
        logic    set_result;
        status_t result_code;
        logic    rd_link;
        logic    push;
        logic    pop;
        logic    row_clear;
        logic    row_inc;
        logic    show_rows;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic list_empty;
        logic id_valid;
        logic row_last;
        logic init_last;
    } ctrl_sts_t;

    function automatic logic [ROWWORD_W-1:0] expand_row(input logic [SRC_W-1:0] src,
                                                        input logic [PAL_W-1:0] palette);
        logic [ROWWORD_W-1:0] word;
        logic [1:0]           sel;
        word = '0;
        for (int p = 0; p < ROWS; p++)
        begin
            sel = src[2*p +: 2];
            word[PIX_W*p +: PIX_W] = palette[PIX_W*sel +: PIX_W];
        end
        return word;
    endfunction

endpackage

`default_nettype wire

### rtl/tile_free_list_allocator_unit.sv
// Top level of the tile free-list allocator: stream ports around controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// After reset the unit writes the initial free list into its link memory, one entry
// per tile, and accepts no request until that pass ends. A request is then taken when
// s_tvalid and s_tready are high; s_tready is high only while no request is in work.
// A successful allocate goes through accept, decode and link memory read at the head,
// loading the new head from the registered read data, then eight row transactions, one
// per cycle while m_tready holds high. A free, an ignored free or an allocate from an
// empty list goes through accept, decode and list update, then one result transaction.
// The registered link memory read adds the head load step to an allocate, and its eight
// row transactions keep the unit from taking a new request until the last is taken.
module tile_free_list_allocator_unit
    import tfla_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tile_id[15:0], palette[47:16], source_rows_low[111:48], source_rows_high[175:112]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // mode
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // result_id[15:0], row_index[18:16], pixel_row[82:19], zero fill[87:83]
    output logic [M_DATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);

    ctrl_cmd_t               cmd;
    ctrl_sts_t               sts;
    status_t                 res_status;
    logic [ID_W-1:0]         res_id;
    logic [ROW_W-1:0]        res_row;
    logic [ROWWORD_W-1:0]    res_pixels;

    tfla_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_last  (m_tlast)
    );

    tfla_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_mode      (s_tuser),
        .req_tile_id   (s_tdata[15:0]),
        .req_palette   (s_tdata[47:16]),
        .req_rows_low  (s_tdata[111:48]),
        .req_rows_high (s_tdata[175:112]),
        .res_status    (res_status),
        .res_id        (res_id),
        .res_row       (res_row),
        .res_pixels    (res_pixels)
    );

    assign m_tdata = {(M_DATA_W - ID_W - ROW_W - ROWWORD_W)'(0), res_pixels, res_row, res_id};
    assign m_tuser = res_status;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("request accepted while a result is pending");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("unit not idle after final result transaction");

    a_multi_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> res_status == STS_ALLOCATED)
        else $error("non-final result for a request other than a successful allocate");

    a_overflow_null: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_status == STS_OVERFLOW |-> res_id == '0 && m_tlast)
        else $error("overflow result without the null id");

    a_alloc_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_status == STS_ALLOCATED
            |-> res_id != '0 && res_id <= ID_W'(NUM_TILES))
        else $error("allocated id outside the pool");
`endif

endmodule

`default_nettype wire

### rtl/tfla_datapath.sv
// Datapath: request registers, free-list head, link memory, row counter and pixel expansion.
`timescale 1ns / 1ps
`default_nettype none

module tfla_datapath
    import tfla_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    output ctrl_sts_t                 sts,
    input  wire logic                 req_mode,
    input  wire logic [ID_W-1:0]      req_tile_id,
    input  wire logic [PAL_W-1:0]     req_palette,
    input  wire logic [HALF_W-1:0]    req_rows_low,
    input  wire logic [HALF_W-1:0]    req_rows_high,
    output status_t                   res_status,
    output logic [ID_W-1:0]           res_id,
    output logic [ROW_W-1:0]          res_row,
    output logic [ROWWORD_W-1:0]      res_pixels
);

    logic                 mode_reg;
    logic [ID_W-1:0]      tile_id_reg;
    logic [PAL_W-1:0]     palette_reg;
    logic [HALF_W-1:0]    rows_low_reg;
    logic [HALF_W-1:0]    rows_high_reg;
    status_t              status_reg;
    logic [ID_W-1:0]      result_id_reg;

    logic [LINK_W-1:0]    head_reg;
    logic [LINK_W-1:0]    head_next;
    logic [ROW_W-1:0]     row_cnt_reg;
    logic [ADDR_W-1:0]    init_cnt_reg;

    logic [LINK_W-1:0]    link_mem [NUM_TILES];
    logic [LINK_W-1:0]    link_rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [LINK_W-1:0]    mem_wdata;

    logic [ID_W-1:0]      id_minus_one;
    logic [HALF_W-1:0]    half_sel;
    logic [SRC_W-1:0]     src_row;

    assign id_minus_one = tile_id_reg - ID_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg      <= req_mode;
            tile_id_reg   <= req_tile_id;
            palette_reg   <= req_palette;
            rows_low_reg  <= req_rows_low;
            rows_high_reg <= req_rows_high;
        end
        if (cmd.set_result)
        begin
            status_reg <= cmd.result_code;
            case (cmd.result_code)
                STS_ALLOCATED: result_id_reg <= ID_W'(head_reg) + ID_W'(1);
                STS_OVERFLOW:  result_id_reg <= '0;
                default:       result_id_reg <= tile_id_reg;
            endcase
        end
    end

    always_comb
    begin
        head_next = head_reg;
        if (cmd.push)
            head_next = id_minus_one[LINK_W-1:0];
        else if (cmd.pop)
            head_next = link_rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            row_cnt_reg  <= '0;
            init_cnt_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            if (cmd.row_clear)
                row_cnt_reg <= '0;
            else if (cmd.row_inc)
                row_cnt_reg <= row_cnt_reg + ROW_W'(1);
            if (cmd.init_wr)
                init_cnt_reg <= init_cnt_reg + ADDR_W'(1);
        end
    end

    // Link memory: the clearing pass writes i+1, a free pushes the old head.
    always_comb
    begin
        mem_we    = cmd.init_wr | cmd.push;
        mem_waddr = cmd.init_wr ? init_cnt_reg : id_minus_one[ADDR_W-1:0];
        mem_wdata = cmd.init_wr ? (LINK_W'(init_cnt_reg) + LINK_W'(1)) : head_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        if (cmd.rd_link)
            link_rdata_reg <= link_mem[head_reg[ADDR_W-1:0]];
    end

    always_comb
    begin
        sts.is_alloc   = !mode_reg;
        sts.list_empty = head_reg >= LINK_W'(NUM_TILES);
        sts.id_valid   = (tile_id_reg != '0) && (tile_id_reg <= ID_W'(NUM_TILES));
        sts.row_last   = row_cnt_reg == ROW_W'(ROWS - 1);
        sts.init_last  = init_cnt_reg == ADDR_W'(NUM_TILES - 1);
    end

    assign half_sel = row_cnt_reg[2] ? rows_high_reg : rows_low_reg;
    assign src_row  = half_sel[SRC_W*row_cnt_reg[1:0] +: SRC_W];

    assign res_status = status_reg;
    assign res_id     = result_id_reg;
    assign res_row    = cmd.show_rows ? row_cnt_reg : '0;
    assign res_pixels = cmd.show_rows ? expand_row(src_row, palette_reg) : '0;

endmodule

`default_nettype wire

### rtl/tfla_controller.sv
// Controller: sequences list initialization, request decode, link lookup and result transactions.
`timescale 1ns / 1ps
`default_nettype none

module tfla_controller
    import tfla_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      out_ready,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd,
    output logic           in_ready,
    output logic           out_valid,
    output logic           out_last
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sts.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.is_alloc && !sts.list_empty)
                    state_next = ST_LINK;
                else
                    state_next = ST_SINGLE;
            end
            ST_LINK:
                state_next = ST_ROWS;
            ST_ROWS:
            begin
                if (out_ready && sts.row_last)
                    state_next = ST_IDLE;
            end
            ST_SINGLE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.result_code = STS_ALLOCATED;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        out_last        = 1'b0;
        case (state_reg)
            ST_INIT:
                cmd.init_wr = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECIDE:
            begin
                cmd.set_result = 1'b1;
                cmd.row_clear  = 1'b1;
                if (sts.is_alloc)
                begin
                    if (sts.list_empty)
                        cmd.result_code = STS_OVERFLOW;
                    else
                    begin
                        cmd.result_code = STS_ALLOCATED;
                        cmd.rd_link     = 1'b1;
                    end
                end
                else if (sts.id_valid)
                begin
                    cmd.result_code = STS_FREED;
                    cmd.push        = 1'b1;
                end
                else
                    cmd.result_code = STS_IGNORED;
            end
            ST_LINK:
                cmd.pop = 1'b1;
            ST_ROWS:
            begin
                out_valid     = 1'b1;
                out_last      = sts.row_last;
                cmd.show_rows = 1'b1;
                cmd.row_inc   = out_ready && !sts.row_last;
            end
            ST_SINGLE:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
